### hw/rtl/gms_pkg.sv
// Shared types and constants for the greedy medoid selector.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package gms_pkg;

  localparam int IDX_W   = 5;   // sample index width
  localparam int DIST_W  = 16;  // distance width, unsigned fixed point
  localparam int CNT_W   = 6;   // sample count / limit width
  localparam int ACC_W   = 21;  // 32 samples * 16-bit distances, exact
  localparam int MASK_W  = 32;  // one bit per possible sample
  localparam int CAP_MAX = 32;  // most samples any run can use

  localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd8;
  localparam logic [CNT_W-1:0] LIMIT_MAX   = 6'd32;

  // configuration register index (from paddr[2])
  localparam logic REG_LIMIT = 1'b0;

  // input request kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_START = 1'b1;

endpackage

`default_nettype wire

### hw/rtl/gms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/greedy_medoid_selector.sv
// Greedy medoid selector top level: distance store, scan sequencer, output register.
// Depends on gms_pkg and gms_ram.
// Write requests are accepted back to back. Start request with n samples, limit L:
//   n <= L: no search, all n samples are results (n = 0: one empty_set result).
//   n > L: L rounds, each an evaluation pass over the unchosen candidates and an
//   update pass, paced by the single store read port, then an output scan, stalled
//   by the result stream. Not ready while a start is in progress.
// Reset clears control state, the chosen mask and sets medoid_limit to 8;
// the distance store is not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module greedy_medoid_selector #(
  parameter int MAX_SAMPLES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [4:0] row_index, [9:5] column_index, [25:10] distance_value, [31:26] start count
  input  wire logic [31:0] s_axis_tdata,
  // [0] command
  input  wire logic        s_axis_tuser,
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [4:0] medoid_index, [7:5] zero
  output      logic [7:0]  m_axis_tdata,
  output      logic        m_axis_tlast,   // last_of_run
  // [0] empty_set
  output      logic        m_axis_tuser,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import gms_pkg::*;

  localparam int DEPTH = MAX_SAMPLES * MAX_SAMPLES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CAP   = (MAX_SAMPLES < CAP_MAX) ? MAX_SAMPLES : CAP_MAX;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  function automatic logic [AW-1:0] mat_addr(input logic [CNT_W-1:0] r,
                                             input logic [CNT_W-1:0] c);
    return AW'(int'(r) * MAX_SAMPLES + int'(c));
  endfunction

  function automatic logic [MASK_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [MASK_W-1:0] m;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

  state_e              state_q;
  logic [CNT_W-1:0]    limit_q;
  logic [CNT_W-1:0]    n_q;
  logic [CNT_W-1:0]    lim_q;
  logic [CNT_W-1:0]    round_q;
  logic [CNT_W-1:0]    c_q;
  logic [CNT_W-1:0]    s_q;
  logic [IDX_W-1:0]    best_q;
  logic [ACC_W-1:0]    min_cost_q;
  logic                have_q;
  logic                first_q;
  logic [ACC_W-1:0]    acc_q;
  logic [MASK_W-1:0]   mask_q;
  logic [IDX_W-1:0]    e_q;
  logic                empty_q;
  logic [DIST_W-1:0]   near_q [CAP_MAX];
  logic                rd_vld_q;
  logic [IDX_W-1:0]    rd_s_q;
  logic [IDX_W-1:0]    rd_c_q;
  logic                rd_last_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic                out_last_q;
  logic                out_empty_q;

  // input request decode
  logic                in_acc;
  logic [IDX_W-1:0]    in_row;
  logic [IDX_W-1:0]    in_col;
  logic [DIST_W-1:0]   in_dist;
  logic [CNT_W-1:0]    in_count;
  logic [CNT_W-1:0]    n_cap;
  logic [CNT_W-1:0]    lim_eff;
  logic                wr_en;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_row   = s_axis_tdata[4:0];
  assign in_col   = s_axis_tdata[9:5];
  assign in_dist  = s_axis_tdata[25:10];
  assign in_count = s_axis_tdata[31:26];
  assign n_cap    = (in_count > CNT_W'(CAP)) ? CNT_W'(CAP) : in_count;
  assign lim_eff  = (limit_q == '0) ? CNT_W'(1) :
                    ((limit_q > LIMIT_MAX) ? LIMIT_MAX : limit_q);
  assign wr_en    = in_acc && (s_axis_tuser == CMD_WRITE) &&
                    (int'(in_row) < MAX_SAMPLES) && (int'(in_col) < MAX_SAMPLES);

  // read issue
  logic                issue;
  logic                cand_taken;
  logic [AW-1:0]       raddr;
  logic [DIST_W-1:0]   rdata;

  assign cand_taken = mask_q[c_q[IDX_W-1:0]];
  always_comb begin
    issue = 1'b0;
    raddr = mat_addr(s_q, c_q);
    case (state_q)
      ST_EVAL: begin
        issue = (c_q < n_q) && !cand_taken;
        raddr = mat_addr(s_q, c_q);
      end
      ST_UPDATE: begin
        issue = (s_q < n_q);
        raddr = mat_addr(s_q, {1'b0, best_q});
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  gms_ram #(
    .WIDTH(DIST_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(mat_addr({1'b0, in_row}, {1'b0, in_col})),
    .wdata_i(in_dist),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // shared min/accumulate unit
  logic [DIST_W-1:0] near_cur;
  logic [DIST_W-1:0] dmin;
  logic [ACC_W-1:0]  sum;
  logic              better;

  assign near_cur = first_q ? {DIST_W{1'b1}} : near_q[rd_s_q];
  assign dmin     = (rdata < near_cur) ? rdata : near_cur;
  assign sum      = ((rd_s_q == '0) ? '0 : acc_q) + ACC_W'(dmin);
  assign better   = !have_q || (sum < min_cost_q);

  // output register
  logic              out_pop;
  logic              out_free;
  logic              out_load;
  logic [MASK_W-1:0] e_bit;
  logic              e_last;

  assign out_pop  = out_valid_q && m_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_EMIT) && out_free && (empty_q || mask_q[e_q]);
  assign e_bit    = MASK_W'(1) << e_q;
  assign e_last   = ((mask_q & ~e_bit) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RESET;
      n_q         <= '0;
      lim_q       <= '0;
      round_q     <= '0;
      c_q         <= '0;
      s_q         <= '0;
      best_q      <= '0;
      min_cost_q  <= '0;
      have_q      <= 1'b0;
      first_q     <= 1'b0;
      acc_q       <= '0;
      mask_q      <= '0;
      e_q         <= '0;
      empty_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_s_q      <= '0;
      rd_c_q      <= '0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == REG_LIMIT)) begin
        limit_q <= pwdata[CNT_W-1:0];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end

      // read pipeline stage
      rd_vld_q  <= issue;
      rd_s_q    <= s_q[IDX_W-1:0];
      rd_c_q    <= c_q[IDX_W-1:0];
      rd_last_q <= (s_q == n_q - CNT_W'(1));

      if (rd_vld_q && (state_q == ST_EVAL)) begin
        acc_q <= sum;
        if (rd_last_q && better) begin
          best_q     <= rd_c_q;
          min_cost_q <= sum;
          have_q     <= 1'b1;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && (s_axis_tuser == CMD_START)) begin
            n_q     <= n_cap;
            lim_q   <= lim_eff;
            e_q     <= '0;
            round_q <= '0;
            c_q     <= '0;
            s_q     <= '0;
            have_q  <= 1'b0;
            first_q <= 1'b1;
            if (n_cap == '0) begin
              mask_q  <= '0;
              empty_q <= 1'b1;
              state_q <= ST_EMIT;
            end else if (n_cap <= lim_eff) begin
              mask_q  <= low_mask(n_cap);
              empty_q <= 1'b0;
              state_q <= ST_EMIT;
            end else begin
              mask_q  <= '0;
              empty_q <= 1'b0;
              state_q <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          if (c_q < n_q) begin
            if (cand_taken) begin
              c_q <= c_q + CNT_W'(1);
            end else if (s_q == n_q - CNT_W'(1)) begin
              s_q <= '0;
              c_q <= c_q + CNT_W'(1);
            end else begin
              s_q <= s_q + CNT_W'(1);
            end
          end else if (!rd_vld_q) begin
            mask_q[best_q] <= 1'b1;
            s_q            <= '0;
            state_q        <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (s_q < n_q) begin
            s_q <= s_q + CNT_W'(1);
          end else if (!rd_vld_q) begin
            first_q <= 1'b0;
            round_q <= round_q + CNT_W'(1);
            c_q     <= '0;
            s_q     <= '0;
            have_q  <= 1'b0;
            if (round_q + CNT_W'(1) == lim_q) begin
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_EVAL;
            end
          end
        end
        ST_EMIT: begin
          // out_valid_q is raised by out_load above
          if (out_free) begin
            if (empty_q) begin
              out_idx_q   <= '0;
              out_last_q  <= 1'b1;
              out_empty_q <= 1'b1;
              empty_q     <= 1'b0;
              state_q     <= ST_IDLE;
            end else begin
              e_q <= e_q + IDX_W'(1);
              if (mask_q[e_q]) begin
                out_idx_q   <= e_q;
                out_last_q  <= e_last;
                out_empty_q <= 1'b0;
                mask_q[e_q] <= 1'b0;
                if (e_last) begin
                  state_q <= ST_IDLE;
                end
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // nearest chosen distance per sample; first round overrides stale contents
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && (state_q == ST_UPDATE)) begin
      near_q[rd_s_q] <= dmin;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_idx_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_empty_q;

  assign prdata = {{(32 - CNT_W){1'b0}},
                   (paddr[2] == REG_LIMIT) ? limit_q : {CNT_W{1'b0}}};
  assign pready = 1'b1;

  // search in progress holds off new requests
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL || state_q == ST_UPDATE) |-> !s_axis_tready)
    else $error("input ready during search");

  // reads in flight only during the search phases
  a_read_in_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_EVAL || state_q == ST_UPDATE))
    else $error("store read outside search");

  // empty result is always the last of its run
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> out_last_q)
    else $error("empty result not marked last");

  // output scan always has a pending index unless it is the empty case
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !empty_q) |-> (mask_q != '0))
    else $error("output scan with nothing left");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_idx_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
